// ===== hdl/sqrt_with_decimal_digits_core_macros.svh =====
// Assertion macros shared by the square root core and its divider.
`ifndef SQRT_WITH_DECIMAL_DIGITS_CORE_MACROS_SVH
`define SQRT_WITH_DECIMAL_DIGITS_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge of clk while rst_n is high.
`define SQRTD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition in one cycle implies another in the next.
`define SQRTD_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);
`else
`define SQRTD_ASSERT(label, prop, msg)
`define SQRTD_ASSERT_NEXT(label, cond, conseq, msg)
`endif

`endif

// ===== hdl/sqrtd_pkg.sv =====
// Types and constants of the square root core.
package sqrtd_pkg;

    localparam int ITERATIONS = 50;
    localparam int MAX_DIGITS = 15;

    localparam int RADICAND_W = 32;
    localparam int COUNT_W    = 4;
    localparam int VALUE_W    = 8;
    localparam int FRAC_W     = 16;

    localparam int DIVIDEND_W = RADICAND_W + FRAC_W;
    localparam int DIVISOR_W  = RADICAND_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam int ITER_W     = $clog2(ITERATIONS);

    localparam logic KIND_INT   = 1'b0;
    localparam logic KIND_DIGIT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITER,
        ST_WAIT,
        ST_INT,
        ST_DIG
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== hdl/sqrtd_div.sv =====
// Restoring divider: one quotient bit per cycle, shared by every Newton step.
`include "sqrt_with_decimal_digits_core_macros.svh"

module sqrtd_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [sqrtd_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [sqrtd_pkg::DIVISOR_W-1:0]     divisor,
    output logic [sqrtd_pkg::DIVIDEND_W-1:0]    quotient,
    output sqrtd_pkg::div_status_t              status
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [sqrtd_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [sqrtd_pkg::DIVISOR_W-1:0]    rem_reg, rem_next;
    logic [sqrtd_pkg::DIVIDEND_W-1:0]   quo_reg, quo_next;
    logic [sqrtd_pkg::DIVISOR_W-1:0]    dvs_reg, dvs_next;

    logic [sqrtd_pkg::DIVISOR_W:0]      partial;
    logic [sqrtd_pkg::DIVISOR_W:0]      diff;
    logic                               fits;

    assign partial = {rem_reg, quo_reg[sqrtd_pkg::DIVIDEND_W-1]};
    assign diff    = partial - {1'b0, dvs_reg};
    assign fits    = partial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (busy_reg)
        begin
            // shift one dividend bit in, subtract where the divisor fits
            rem_next = fits ? diff[sqrtd_pkg::DIVISOR_W-1:0]
                            : partial[sqrtd_pkg::DIVISOR_W-1:0];
            quo_next = {quo_reg[sqrtd_pkg::DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == sqrtd_pkg::DIV_CNT_W'(sqrtd_pkg::DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    `SQRTD_ASSERT(a_done_after_busy, !done_reg || $past(busy_reg), "done without a division")
    `SQRTD_ASSERT(a_no_start_busy, !(start && busy_reg), "start while dividing")
    `SQRTD_ASSERT(a_rem_below_dvs, !busy_reg || (rem_reg < dvs_reg), "remainder not below divisor")

endmodule

// ===== hdl/sqrt_with_decimal_digits_core.sv =====
// Newton square root of a Q16.16 value with decimal fraction digit output.
//
//  channel   handshake                 fields
//  input     start / busy              radicand[31:0], digit_count[3:0]
//  result    result_valid (strobe)     kind, value[7:0], last
//
//  An item is taken when start is high and busy is low; busy then stays high
//  until the last result has been registered.
//  Each of the 50 Newton steps runs one 48/32 bit division on the shared
//  restoring divider; a zero radicand skips the divider entirely.
//  The integer part comes first, then one digit per cycle.
//  Results are one-cycle strobes; the receiver cannot stall them.
//  Reset is asynchronous, active low, and leaves the core idle.
`include "sqrt_with_decimal_digits_core_macros.svh"

module sqrt_with_decimal_digits_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sqrtd_pkg::RADICAND_W-1:0]    radicand,
    input  logic [sqrtd_pkg::COUNT_W-1:0]       digit_count,
    output logic                                result_valid,
    output logic                                kind,
    output logic [sqrtd_pkg::VALUE_W-1:0]       value,
    output logic                                last
);

    sqrtd_pkg::state_t                  state_reg, state_next;
    logic [sqrtd_pkg::ITER_W-1:0]       iter_reg, iter_next;
    logic [sqrtd_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [sqrtd_pkg::COUNT_W-1:0]      dig_reg, dig_next;
    logic [sqrtd_pkg::RADICAND_W-1:0]   n_reg, n_next;
    logic [sqrtd_pkg::RADICAND_W-1:0]   x_reg, x_next;
    logic [sqrtd_pkg::FRAC_W-1:0]       frac_reg, frac_next;

    logic                               valid_reg, valid_next;
    logic                               kind_reg, kind_next;
    logic [sqrtd_pkg::VALUE_W-1:0]      value_reg, value_next;
    logic                               last_reg, last_next;

    logic                               div_start;
    logic [sqrtd_pkg::DIVIDEND_W-1:0]   quotient;
    sqrtd_pkg::div_status_t             div_status;

    logic [sqrtd_pkg::DIVIDEND_W:0]     sum;
    logic                               sat;
    logic [sqrtd_pkg::FRAC_W+3:0]       times_ten;
    logic [sqrtd_pkg::COUNT_W-1:0]      dig_inc;

    sqrtd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({n_reg, {sqrtd_pkg::FRAC_W{1'b0}}}),
        .divisor  (x_reg),
        .quotient (quotient),
        .status   (div_status)
    );

    assign sum       = {1'b0, quotient} + (sqrtd_pkg::DIVIDEND_W + 1)'(x_reg);
    assign sat       = |x_reg[sqrtd_pkg::RADICAND_W-1:sqrtd_pkg::FRAC_W+sqrtd_pkg::VALUE_W];
    assign times_ten = ({4'd0, frac_reg} << 3) + ({4'd0, frac_reg} << 1);
    assign dig_inc   = dig_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        count_next = count_reg;
        dig_next   = dig_reg;
        n_next     = n_reg;
        x_next     = x_reg;
        frac_next  = frac_reg;
        valid_next = 1'b0;
        kind_next  = kind_reg;
        value_next = value_reg;
        last_next  = last_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            sqrtd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    n_next    = radicand;
                    x_next    = radicand;
                    iter_next = '0;
                    dig_next  = '0;
                    if (int'(digit_count) > sqrtd_pkg::MAX_DIGITS)
                        count_next = sqrtd_pkg::COUNT_W'(sqrtd_pkg::MAX_DIGITS);
                    else
                        count_next = digit_count;
                    // zero radicand: root is zero, skip the divider
                    state_next = (radicand == '0) ? sqrtd_pkg::ST_INT : sqrtd_pkg::ST_ITER;
                end
            end
            sqrtd_pkg::ST_ITER:
            begin
                div_start  = 1'b1;
                state_next = sqrtd_pkg::ST_WAIT;
            end
            sqrtd_pkg::ST_WAIT:
            begin
                if (div_status.done)
                begin
                    x_next    = sum[sqrtd_pkg::RADICAND_W:1];
                    iter_next = iter_reg + 1'b1;
                    if (iter_reg == sqrtd_pkg::ITER_W'(sqrtd_pkg::ITERATIONS - 1))
                        state_next = sqrtd_pkg::ST_INT;
                    else
                        state_next = sqrtd_pkg::ST_ITER;
                end
            end
            sqrtd_pkg::ST_INT:
            begin
                // saturate a root that settled at 256.0 or above
                valid_next = 1'b1;
                kind_next  = sqrtd_pkg::KIND_INT;
                value_next = sat ? '1
                                 : x_reg[sqrtd_pkg::FRAC_W+sqrtd_pkg::VALUE_W-1:sqrtd_pkg::FRAC_W];
                frac_next  = sat ? '1 : x_reg[sqrtd_pkg::FRAC_W-1:0];
                last_next  = (count_reg == '0);
                state_next = (count_reg == '0) ? sqrtd_pkg::ST_IDLE : sqrtd_pkg::ST_DIG;
            end
            sqrtd_pkg::ST_DIG:
            begin
                valid_next = 1'b1;
                kind_next  = sqrtd_pkg::KIND_DIGIT;
                value_next = sqrtd_pkg::VALUE_W'(times_ten[sqrtd_pkg::FRAC_W+3:sqrtd_pkg::FRAC_W]);
                frac_next  = times_ten[sqrtd_pkg::FRAC_W-1:0];
                dig_next   = dig_inc;
                last_next  = (dig_inc == count_reg);
                if (dig_inc == count_reg)
                    state_next = sqrtd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sqrtd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sqrtd_pkg::ST_IDLE;
            valid_reg <= 1'b0;
            iter_reg  <= '0;
            dig_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            iter_reg  <= iter_next;
            dig_reg   <= dig_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        n_reg     <= n_next;
        x_reg     <= x_next;
        frac_reg  <= frac_next;
        kind_reg  <= kind_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign busy         = (state_reg != sqrtd_pkg::ST_IDLE);
    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign value        = value_reg;
    assign last         = last_reg;

    `SQRTD_ASSERT(a_digit_range, !(valid_reg && kind_reg) || (value_reg <= 8'd9), "digit above nine")
    `SQRTD_ASSERT(a_div_nonzero, !div_start || (x_reg != '0), "division by a zero estimate")
    `SQRTD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `SQRTD_ASSERT_NEXT(a_last_ends, valid_reg && last_reg, !valid_reg, "result after last beat")
    `SQRTD_ASSERT(a_div_idle_emit, !valid_reg || !div_status.busy, "result while dividing")

endmodule
